>>> src/signed_radix_digit_emitter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed radix digit emitter
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RADIX_DIGIT_EMITTER_UNIT_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset
`define SRDE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define SRDE_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/srde_pkg.sv
// ----------------------------------------------------------------------------
// srde_pkg
// Types and constants shared by the signed radix digit emitter.
// ----------------------------------------------------------------------------
package srde_pkg;

  // Datapath widths
  localparam int DATA_W        = 32;
  localparam int SYM_W         = 8;
  localparam int DIVISOR_W     = 5;
  localparam int REM_W         = 4;

  // Divider: eight quotient bits per cycle
  localparam int DIV_STEP_BITS = 8;
  localparam int DIV_STEPS     = DATA_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  // Digit buffer
  localparam int DIGITS_MAX    = 32;
  localparam int DIGIT_IDX_W   = $clog2(DIGITS_MAX);
  localparam int DIGIT_CNT_W   = DIGIT_IDX_W + 1;

  // Sign symbols and smallest usable radix
  localparam logic [SYM_W-1:0]     SIGN_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]     SIGN_MINUS = 8'h2D;
  localparam logic [DIVISOR_W-1:0] MIN_RADIX  = 5'd2;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_RADIX        = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [DIVISOR_W-1:0]  RADIX_RST        = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [DATA_W-1:0]    dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [REM_W-1:0]  remainder;
  } div_rsp_t;

endpackage

>>> src/srde_stream_if.sv
// ----------------------------------------------------------------------------
// srde stream interfaces
// Valid/ready channels for the input value and the output symbols.
// ----------------------------------------------------------------------------
interface srde_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [srde_pkg::DATA_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface srde_out_if;
  logic                          valid;
  logic                          ready;
  logic [srde_pkg::SYM_W-1:0]    symbol;
  logic                          last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

>>> src/srde_divider.sv
// ----------------------------------------------------------------------------
// srde_divider
// Iterative unsigned divider, 32-bit dividend by a small divisor (2..16).
// Restoring division, eight quotient bits per cycle; done pulses when the
// quotient and remainder are ready.
// ----------------------------------------------------------------------------
module srde_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  srde_pkg::div_req_t req,
  output srde_pkg::div_rsp_t rsp
);

  logic                               busy_r;
  logic                               done_r;
  logic [srde_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [srde_pkg::DATA_W-1:0]        quo_r;
  logic [srde_pkg::DATA_W-1:0]        quo_nxt;
  logic [srde_pkg::REM_W-1:0]         rem_r;
  logic [srde_pkg::REM_W-1:0]         rem_nxt;
  logic [srde_pkg::DIVISOR_W-1:0]     dvs_r;

  // One step: eight compare/subtract stages on the narrow remainder
  always_comb begin
    logic [srde_pkg::REM_W-1:0]         rem_v;
    logic [srde_pkg::DIVISOR_W-1:0]     trial;
    logic [srde_pkg::DIV_STEP_BITS-1:0] qbits;
    rem_v = rem_r;
    qbits = '0;
    for (int i = 0; i < srde_pkg::DIV_STEP_BITS; i++) begin
      trial = {rem_v, quo_r[srde_pkg::DATA_W-1-i]};
      if (trial >= dvs_r) begin
        qbits[srde_pkg::DIV_STEP_BITS-1-i] = 1'b1;
        rem_v = srde_pkg::REM_W'(trial - dvs_r);
      end else begin
        rem_v = srde_pkg::REM_W'(trial);
      end
    end
    rem_nxt = rem_v;
    quo_nxt = {quo_r[srde_pkg::DATA_W-srde_pkg::DIV_STEP_BITS-1:0], qbits};
  end

  // Dividend bits shift out at the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == srde_pkg::DIV_CNT_W'(srde_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> src/signed_radix_digit_emitter_unit.sv
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_unit
// Writes a signed 32-bit value as text in a configured radix, one symbol
// byte per output transfer, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one signed 32-bit value per transfer (valid/ready).
//   out_chan : symbol bytes; a leading '-' for negatives, then the digits;
//              last marks the final symbol of each number.
//   cfg_*    : APB-style port; radix at 0x00, symbols 0..7 at 0x08,
//              symbols 8..15 at 0x10. Write only while the block is idle.
//   The alphabet is checked one symbol per cycle. A bad
//   radix or alphabet drops the value with no output. Each digit then
//   takes one pass of the shared divider, started from S_DIV_GO and
//   awaited in S_DIV_WAIT, and each symbol goes out via the output register.
//   in_chan is ready only when the sequencer is idle.
//   When the receiver stalls, the output register holds its symbol and the
//   sequencer waits. Reset restores radix 10 and the alphabet "0".."9",
//   and empties the output register.
// ----------------------------------------------------------------------------
`include "signed_radix_digit_emitter_unit_defines.svh"

module signed_radix_digit_emitter_unit #(
  parameter int MAX_BASE = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  srde_in_if.sink                           in_chan,
  srde_out_if.source                        out_chan,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [srde_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [srde_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [srde_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int IDX_W = $clog2(MAX_BASE);
  localparam logic [srde_pkg::DIVISOR_W-1:0] MAX_RADIX = srde_pkg::DIVISOR_W'(MAX_BASE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SIGN,
    S_EMIT
  } state_t;

  // Configuration registers
  logic [srde_pkg::DIVISOR_W-1:0]   radix_r;
  logic [srde_pkg::CFG_DATA_W-1:0]  symbols_low_r;
  logic [srde_pkg::CFG_DATA_W-1:0]  symbols_high_r;
  logic                             cfg_wr;
  logic [srde_pkg::REG_IDX_W-1:0]   cfg_idx;

  // Sequencer and datapath
  state_t                              state_r;
  logic [srde_pkg::DATA_W-1:0]         mag_r;
  logic                                neg_r;
  logic [IDX_W-1:0]                    idx_r;
  logic [srde_pkg::DIGIT_CNT_W-1:0]    nd_r;
  logic [srde_pkg::DIGIT_IDX_W-1:0]    rd_r;
  logic [IDX_W-1:0]                    digit_r [srde_pkg::DIGITS_MAX];
  logic                                out_valid_r;
  logic [srde_pkg::SYM_W-1:0]          symbol_r;
  logic                                last_r;

  logic [2*srde_pkg::CFG_DATA_W-1:0]   sym_all;
  logic [srde_pkg::SYM_W-1:0]          sym_tab [MAX_BASE];
  logic [IDX_W-1:0]                    sym_sel;
  logic [srde_pkg::SYM_W-1:0]          sym_rd;
  logic [srde_pkg::DIVISOR_W-1:0]      idx_ext;
  logic                                radix_ok;
  logic                                sym_dup;
  logic                                sym_bad;
  logic                                idx_last;
  logic                                out_free;
  logic                                out_load;
  logic                                div_more;

  srde_pkg::div_req_t div_req;
  srde_pkg::div_rsp_t div_rsp;

  // ---------------------------------------------------------------------------
  // Configuration port: index from address bits [4:3], ready always high
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[srde_pkg::CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r        <= srde_pkg::RADIX_RST;
      symbols_low_r  <= srde_pkg::SYMBOLS_LOW_RST;
      symbols_high_r <= srde_pkg::SYMBOLS_HIGH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srde_pkg::REG_RADIX:        radix_r <= cfg_pwdata[srde_pkg::DIVISOR_W-1:0];
        srde_pkg::REG_SYMBOLS_LOW:  symbols_low_r <= cfg_pwdata;
        srde_pkg::REG_SYMBOLS_HIGH: symbols_high_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      srde_pkg::REG_RADIX:        cfg_prdata = srde_pkg::CFG_DATA_W'(radix_r);
      srde_pkg::REG_SYMBOLS_LOW:  cfg_prdata = symbols_low_r;
      srde_pkg::REG_SYMBOLS_HIGH: cfg_prdata = symbols_high_r;
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Symbol table; the sym_sel read port is shared by the check and the emit phase
  assign sym_all = {symbols_high_r, symbols_low_r};

  always_comb begin
    for (int k = 0; k < MAX_BASE; k++) begin
      sym_tab[k] = sym_all[srde_pkg::SYM_W*k +: srde_pkg::SYM_W];
    end
  end

  assign sym_sel = (state_r == S_CHECK) ? idx_r : digit_r[rd_r];
  assign sym_rd  = sym_tab[sym_sel];

  // Alphabet check for the symbol at idx_r against all later symbols in use
  assign idx_ext  = srde_pkg::DIVISOR_W'(idx_r);
  assign radix_ok = (radix_r >= srde_pkg::MIN_RADIX) && (radix_r <= MAX_RADIX);
  assign idx_last = (idx_ext + 1'b1) == radix_r;

  always_comb begin
    sym_dup = 1'b0;
    for (int b = 0; b < MAX_BASE; b++) begin
      if ((srde_pkg::DIVISOR_W'(b) > idx_ext) && (srde_pkg::DIVISOR_W'(b) < radix_r) &&
          (sym_tab[b] == sym_rd)) begin
        sym_dup = 1'b1;
      end
    end
  end

  assign sym_bad = (sym_rd == srde_pkg::SIGN_PLUS) || (sym_rd == srde_pkg::SIGN_MINUS) ||
                   sym_dup;

  // ---------------------------------------------------------------------------
  // Shared divider
  assign div_req.start    = (state_r == S_DIV_GO);
  assign div_req.dividend = mag_r;
  assign div_req.divisor  = radix_r;

  srde_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // More digits while the quotient is nonzero and the buffer has room
  assign div_more = (div_rsp.quotient != '0) &&
                    (nd_r != srde_pkg::DIGIT_CNT_W'(srde_pkg::DIGITS_MAX - 1));

  assign out_free = !out_valid_r || out_chan.ready;
  // A symbol enters the output register this cycle
  assign out_load = ((state_r == S_SIGN) || (state_r == S_EMIT)) && out_free;

  // ---------------------------------------------------------------------------
  // Sequencer with the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      nd_r        <= '0;
      rd_r        <= '0;
    end else begin
      if (out_valid_r && out_chan.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            neg_r   <= in_chan.value[srde_pkg::DATA_W-1];
            mag_r   <= in_chan.value[srde_pkg::DATA_W-1] ?
                       (srde_pkg::DATA_W'(0) - in_chan.value) : in_chan.value;
            idx_r   <= '0;
            nd_r    <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!radix_ok || sym_bad) begin
            state_r <= S_IDLE;
          end else if (idx_last) begin
            state_r <= S_DIV_GO;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            digit_r[nd_r[srde_pkg::DIGIT_IDX_W-1:0]] <= IDX_W'(div_rsp.remainder);
            nd_r  <= nd_r + 1'b1;
            mag_r <= div_rsp.quotient;
            rd_r  <= nd_r[srde_pkg::DIGIT_IDX_W-1:0];
            if (div_more) begin
              state_r <= S_DIV_GO;
            end else if (neg_r) begin
              state_r <= S_SIGN;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            symbol_r    <= srde_pkg::SIGN_MINUS;
            last_r      <= 1'b0;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            symbol_r    <= sym_rd;
            last_r      <= (rd_r == '0);
            if (rd_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              rd_r <= rd_r - 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready   = (state_r == S_IDLE);
  assign out_chan.valid  = out_valid_r;
  assign out_chan.symbol = symbol_r;
  assign out_chan.last   = last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  `SRDE_ASSERT(a_div_done_in_wait, clk, rst_n, div_rsp.done |-> state_r == S_DIV_WAIT, "divider finished outside wait state")
  `SRDE_ASSERT(a_div_radix_ok, clk, rst_n, (state_r == S_DIV_GO) |-> radix_ok, "division started with a bad radix")
  `SRDE_NEVER(a_nd_bound, clk, rst_n, nd_r > srde_pkg::DIGIT_CNT_W'(srde_pkg::DIGITS_MAX), "digit count overflow")
  `SRDE_ASSERT(a_rd_in_range, clk, rst_n, (state_r == S_EMIT) |-> (srde_pkg::DIGIT_CNT_W'(rd_r) < nd_r), "digit read beyond digits stored")

endmodule

>>> dv/srde_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol stream checker for the signed radix digit emitter
// Snoops the configuration port to keep its own copy of radix and alphabet,
// turns each accepted value into the expected run of symbols, and compares
// every output transfer against the oldest symbol still owed.
// ----------------------------------------------------------------------------
module srde_checker
  import srde_pkg::*;
#(
  parameter int MAX_BASE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  srde_in_if                    in_mon,
  srde_out_if                   out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int unsigned           fail_cnt,
  output int unsigned           pending_cnt
);

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } sym_beat_t;

  // local copy of the register file
  logic [DIVISOR_W-1:0]  radix_q  = RADIX_RST;
  logic [CFG_DATA_W-1:0] sym_lo_q = SYMBOLS_LOW_RST;
  logic [CFG_DATA_W-1:0] sym_hi_q = SYMBOLS_HIGH_RST;

  sym_beat_t   text_q[$];
  int unsigned fails = 0;

  assign fail_cnt = fails;

  function automatic logic [SYM_W-1:0] symbol_of(input int k);
    if (k < 8) return sym_lo_q[8*k +: 8];
    return sym_hi_q[8*(k-8) +: 8];
  endfunction

  // radix in range, no sign characters, no duplicates among symbols in use
  function automatic bit alphabet_good();
    int n;
    n = radix_q;
    if (n < MIN_RADIX || n > MAX_BASE) return 1'b0;
    for (int a = 0; a < n; a++) begin
      if (symbol_of(a) == SIGN_PLUS || symbol_of(a) == SIGN_MINUS) return 1'b0;
      for (int b = a + 1; b < n; b++)
        if (symbol_of(b) == symbol_of(a)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the text of one value, most significant digit first
  function automatic void queue_text(input logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] base;
    logic [REM_W-1:0]  digs [0:DIGITS_MAX-1];
    int                nd;
    if (!alphabet_good()) return;
    mag  = raw[DATA_W-1] ? (32'd0 - raw) : raw;
    base = DATA_W'(radix_q);
    nd   = 0;
    do begin
      digs[nd] = REM_W'(mag % base);
      mag      = mag / base;
      nd++;
    end while (mag != 0 && nd < DIGITS_MAX);
    if (raw[DATA_W-1]) text_q.push_back('{symbol: SIGN_MINUS, last: 1'b0});
    for (int k = nd - 1; k >= 0; k--)
      text_q.push_back('{symbol: symbol_of(digs[k]), last: (k == 0)});
  endfunction

  always @(posedge clk) begin : watch
    sym_beat_t want;
    if (!rst_n) begin
      radix_q  = RADIX_RST;
      sym_lo_q = SYMBOLS_LOW_RST;
      sym_hi_q = SYMBOLS_HIGH_RST;
      text_q.delete();
    end else begin
      // output transfer against the oldest owed symbol
      if (out_mon.valid && out_mon.ready) begin
        if (text_q.size() == 0) begin
          $error("unexpected symbol transfer: symbol %h last %b",
                 out_mon.symbol, out_mon.last);
          fails++;
        end else begin
          want = text_q.pop_front();
          if (out_mon.symbol !== want.symbol) begin
            $error("symbol mismatch: expected %h, got %h", want.symbol, out_mon.symbol);
            fails++;
          end
          if (out_mon.last !== want.last) begin
            $error("last mismatch: expected %b, got %b", want.last, out_mon.last);
            fails++;
          end
        end
      end
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1 -: REG_IDX_W])
          REG_RADIX:        radix_q  = cfg_pwdata[DIVISOR_W-1:0];
          REG_SYMBOLS_LOW:  sym_lo_q = cfg_pwdata;
          REG_SYMBOLS_HIGH: sym_hi_q = cfg_pwdata;
          default: ;
        endcase
      end
      // input transfer
      if (in_mon.valid && in_mon.ready) queue_text(in_mon.value);
    end
    pending_cnt = text_q.size();
  end

endmodule

>>> dv/signed_radix_digit_emitter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_unit testbench
// Drives values and register writes into the emitter, with random gaps on
// the input and random stalls on the output, across decimal, binary, hex,
// odd and random alphabets as well as rejected ones. The checker beside the
// block predicts every symbol; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_unit_tb;
  import srde_pkg::*;

  localparam int SETTLE_CYCLES   = 300;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RUN_LIMIT_NS    = 2_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int unsigned           fail_cnt;
  int unsigned           pending_cnt;
  bit                    quiet;
  bit                    hold_req;

  srde_in_if  in_if ();
  srde_out_if out_if ();

  signed_radix_digit_emitter_unit #(
    .MAX_BASE (16)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  srde_checker #(
    .MAX_BASE (16)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // symbol receiver: random stall bursts, one long hold-off on request
  initial begin : result_sink
    int gap;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 4);
        out_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // offer one value and wait for its transfer
  task automatic send_value(input logic [DATA_W-1:0] v);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // stop offering, wait for every owed symbol, then let a dropped value finish
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 3'b000});
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // reprogram while idle; junk in the unused upper bits of the radix word
  task automatic set_regs(input int r, input logic [63:0] lo, input logic [63:0] hi);
    logic [CFG_DATA_W-1:0] word;
    drain();
    word = {$urandom(), $urandom()};
    word[DIVISOR_W-1:0] = DIVISOR_W'(r);
    cfg_write(REG_RADIX, word);
    cfg_write(REG_SYMBOLS_LOW, lo);
    cfg_write(REG_SYMBOLS_HIGH, hi);
  endtask

  // mix of full-range, small and near-extreme values
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] r;
    case ($urandom_range(0, 5))
      0: r = $urandom_range(0, 40);
      1: begin
        r = $urandom_range(0, 40);
        r = 32'd0 - r;
      end
      2: r = 32'h8000_0000 + $urandom_range(0, 3);
      3: r = 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: r = $urandom();
    endcase
    return r;
  endfunction

  task automatic run_random(input int n, input bit calm);
    quiet = calm || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) send_value(pick_value());
  endtask

  // sixteen distinct symbols, none of them a sign
  task automatic pick_alphabet(output logic [63:0] lo, output logic [63:0] hi);
    logic [7:0] b;
    bit         taken [0:255];
    for (int k = 0; k < 16; k++) begin
      do b = $urandom_range(0, 255);
      while (taken[b] || b == SIGN_PLUS || b == SIGN_MINUS);
      taken[b] = 1'b1;
      if (k < 8) lo[8*k +: 8] = b;
      else       hi[8*(k-8) +: 8] = b;
    end
  endtask

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    in_if.valid = 1'b0;
    in_if.value = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // decimal alphabet from reset
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'd9);
    send_value(32'd10);
    send_value(-32'd10);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    run_random(20, 1'b0);
    drain();
    run_random(20, 1'b0);

    // binary: longest runs; long receiver hold-off while values keep coming
    set_regs(2, SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'd0);
    hold_req = 1'b1;
    quiet    = 1'b0;
    for (int i = 0; i < 6; i++) send_value(pick_value());
    run_random(30, 1'b0);

    // lowercase hex, full sixteen symbols
    set_regs(16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0001);
    run_random(40, 1'b0);

    // zero byte and 0xff as symbols; signs and a repeat only past the radix
    set_regs(3, 64'h1111_002B_2D7A_FF00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(32'h8000_0000);
    run_random(20, 1'b0);

    // rejected radix values: no output expected
    set_regs(0, SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST);
    send_value(32'd5);
    set_regs(1, SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST);
    send_value(-32'd5);
    set_regs(17, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    send_value(32'd17);
    set_regs(31, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    send_value(32'h8000_0000);

    // rejected alphabets: plus in use, minus in use, duplicate low, duplicate high
    set_regs(4, 64'h3736_3534_2B32_3130, SYMBOLS_HIGH_RST);
    send_value(32'd123);
    set_regs(10, SYMBOLS_LOW_RST, 64'h0000_0000_0000_2D38);
    send_value(-32'd123);
    set_regs(5, 64'h3736_3530_3332_3130, SYMBOLS_HIGH_RST);
    send_value(32'd77);
    set_regs(16, 64'h3736_3534_3332_3130, 64'h3065_6463_6261_3938);
    send_value(32'd4096);

    // random valid alphabets
    for (int p = 0; p < 6; p++) begin
      pick_alphabet(lo, hi);
      set_regs($urandom_range(2, 16), lo, hi);
      run_random(25, 1'b0);
    end

    // unconstrained registers: some pass the check, most do not
    for (int p = 0; p < 2; p++) begin
      set_regs($urandom_range(0, 31), {$urandom(), $urandom()}, {$urandom(), $urandom()});
      run_random(5, 1'b0);
    end

    // back to decimal, no idling on either side
    set_regs(10, SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST);
    run_random(40, 1'b1);

    drain();
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> signed_radix_digit_emitter_unit.f
+incdir+src
src/srde_pkg.sv
src/srde_stream_if.sv
src/srde_divider.sv
src/signed_radix_digit_emitter_unit.sv
dv/srde_checker.sv
dv/signed_radix_digit_emitter_unit_tb.sv
